// ----- hdl/mcc_pkg.sv -----
// ----------------------------------------------------------------------------
// mcc_pkg
// Shared types and constants of the mouse click classifier: report and
// result payloads, register indexes, register reset values.
// ----------------------------------------------------------------------------
package mcc_pkg;

   localparam int COORD_WIDTH  = 12;
   localparam int TIME_WIDTH   = 32;
   localparam int BTN_WIDTH    = 8;
   localparam int WIN_WIDTH    = 16;
   localparam int COUNT_WIDTH  = 8;
   localparam int CSR_IDX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH = 16;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_CLICK_WIN = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MULTI_WIN = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_WHEEL     = 2'd2;

   localparam logic [WIN_WIDTH-1:0] CLICK_WIN_RESET = 16'd250;
   localparam logic [WIN_WIDTH-1:0] MULTI_WIN_RESET = 16'd500;
   localparam logic [BTN_WIDTH-1:0] WHEEL_RESET     = 8'd24;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   typedef struct packed {
      logic [COORD_WIDTH-1:0] x_pos;
      logic [COORD_WIDTH-1:0] y_pos;
      logic [BTN_WIDTH-1:0]   buttons_in;
      logic [TIME_WIDTH-1:0]  time_ms;
   } req_type;

   typedef struct packed {
      logic                   moved;
      logic                   pressed;
      logic                   released;
      logic                   clicked;
      logic                   hover;
      logic                   held_hint;
      logic [BTN_WIDTH-1:0]   changed_buttons;
      logic [COUNT_WIDTH-1:0] click_count;
      logic [COORD_WIDTH-1:0] old_x;
      logic [COORD_WIDTH-1:0] old_y;
   } rsp_type;

   typedef struct packed {
      logic [WIN_WIDTH-1:0] click_win;
      logic [WIN_WIDTH-1:0] multi_win;
      logic [BTN_WIDTH-1:0] wheel_mask;
   } cfg_type;

endpackage

// ----- hdl/mcc_csr.sv -----
// ----------------------------------------------------------------------------
// mcc_csr
// Configuration registers: click window, multi-click window, wheel mask.
// ----------------------------------------------------------------------------
module mcc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mcc_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [mcc_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   output mcc_pkg::cfg_type                    cfg
);

   mcc_pkg::cfg_type cfg_ff;
   mcc_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            mcc_pkg::CSR_CLICK_WIN: cfg_in.click_win  = csr_data[mcc_pkg::WIN_WIDTH-1:0];
            mcc_pkg::CSR_MULTI_WIN: cfg_in.multi_win  = csr_data[mcc_pkg::WIN_WIDTH-1:0];
            mcc_pkg::CSR_WHEEL:     cfg_in.wheel_mask = csr_data[mcc_pkg::BTN_WIDTH-1:0];
            default: ;  // unmapped index: drop the write
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.click_win  <= mcc_pkg::CLICK_WIN_RESET;
         cfg_ff.multi_win  <= mcc_pkg::MULTI_WIN_RESET;
         cfg_ff.wheel_mask <= mcc_pkg::WHEEL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- hdl/mcc_core.sv -----
// ----------------------------------------------------------------------------
// mcc_core
// Classifies one registered report per cycle while item_valid is high,
// against the tracker state and updates that state in the same cycle.
// ----------------------------------------------------------------------------
module mcc_core (
   input  logic              clock,
   input  logic              reset,
   input  mcc_pkg::cfg_type  cfg,
   input  logic              item_valid,
   input  mcc_pkg::req_type  item,
   output mcc_pkg::rsp_type  result
);

   localparam int CW = mcc_pkg::COORD_WIDTH;
   localparam int TW = mcc_pkg::TIME_WIDTH;
   localparam int BW = mcc_pkg::BTN_WIDTH;
   localparam int NW = mcc_pkg::COUNT_WIDTH;
   localparam int WW = mcc_pkg::WIN_WIDTH;

   logic [CW-1:0] cur_x_ff, cur_y_ff, prev_x_ff, prev_y_ff;
   logic [CW-1:0] cur_x_in, cur_y_in, prev_x_in, prev_y_in;
   logic [CW-1:0] press_x_ff, press_y_ff, press_x_in, press_y_in;
   logic [BW-1:0] held_ff, held_in, press_btn_ff, press_btn_in;
   logic [TW-1:0] last_report_ff, last_report_in, last_click_ff, last_click_in;
   logic [NW-1:0] count_ff, count_in;

   logic          moved, pressed, released, clicked, hover;
   logic [BW-1:0] edge_btn;
   logic [TW-1:0] dt_report, dt_click;
   logic          in_click_win, in_multi_win;

   assign dt_report    = item.time_ms - last_report_ff;
   assign dt_click     = item.time_ms - last_click_ff;
   assign in_click_win = dt_report <= {{(TW-WW){1'b0}}, cfg.click_win};
   assign in_multi_win = dt_click  <= {{(TW-WW){1'b0}}, cfg.multi_win};

   always_comb begin
      moved    = (item.x_pos != cur_x_ff) || (item.y_pos != cur_y_ff);
      pressed  = item.buttons_in > held_ff;
      released = item.buttons_in < held_ff;
      hover    = !pressed && !released;

      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      if (moved) begin
         prev_x_in = cur_x_ff;
         prev_y_in = cur_y_ff;
         cur_x_in  = item.x_pos;
         cur_y_in  = item.y_pos;
      end

      press_x_in    = press_x_ff;
      press_y_in    = press_y_ff;
      press_btn_in  = press_btn_ff;
      last_click_in = last_click_ff;
      count_in      = count_ff;
      clicked       = 1'b0;
      edge_btn      = '0;

      if (pressed) begin
         edge_btn     = item.buttons_in & ~held_ff;
         press_btn_in = edge_btn;
         press_x_in   = cur_x_in;
         press_y_in   = cur_y_in;
      end else if (released) begin
         edge_btn = ~item.buttons_in & held_ff;
         clicked  = (item.buttons_in == '0) && (edge_btn == press_btn_ff) &&
                    (cur_x_in == press_x_ff) && (cur_y_in == press_y_ff) &&
                    in_click_win;
         if (clicked) begin
            last_click_in = item.time_ms;
            if (!in_multi_win) begin
               count_in = NW'(1);
            end else if (count_ff != mcc_pkg::COUNT_MAX) begin
               count_in = count_ff + NW'(1);
            end
         end else begin
            count_in = '0;
         end
      end

      held_in        = item.buttons_in & ~cfg.wheel_mask;
      last_report_in = item.time_ms;

      result.moved           = moved;
      result.pressed         = pressed;
      result.released        = released;
      result.clicked         = clicked;
      result.hover           = hover;
      result.held_hint       = hover && (item.buttons_in != '0);
      result.changed_buttons = edge_btn;
      result.click_count     = count_in;
      result.old_x           = prev_x_in;
      result.old_y           = prev_y_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff       <= '0;
         cur_y_ff       <= '0;
         prev_x_ff      <= '0;
         prev_y_ff      <= '0;
         press_x_ff     <= '0;
         press_y_ff     <= '0;
         held_ff        <= '0;
         press_btn_ff   <= '0;
         last_report_ff <= '0;
         last_click_ff  <= '0;
         count_ff       <= '0;
      end else if (item_valid) begin
         cur_x_ff       <= cur_x_in;
         cur_y_ff       <= cur_y_in;
         prev_x_ff      <= prev_x_in;
         prev_y_ff      <= prev_y_in;
         press_x_ff     <= press_x_in;
         press_y_ff     <= press_y_in;
         held_ff        <= held_in;
         press_btn_ff   <= press_btn_in;
         last_report_ff <= last_report_in;
         last_click_ff  <= last_click_in;
         count_ff       <= count_in;
      end
   end

`ifndef ASSERT_OFF
   a_one_class: assert property (@(posedge clock) disable iff (reset)
      item_valid |-> $onehot({result.pressed, result.released, result.hover}))
      else $error("report not in exactly one button class");

   a_click_release: assert property (@(posedge clock) disable iff (reset)
      (item_valid && result.clicked) |-> (result.released && result.click_count != '0))
      else $error("click without release or with zero count");

   a_count_clear: assert property (@(posedge clock) disable iff (reset)
      (item_valid && result.released && !result.clicked) |=> (count_ff == '0))
      else $error("count not cleared after non-click release");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !item_valid |=> ($stable(count_ff) && $stable(held_ff) && $stable(last_report_ff)))
      else $error("tracker state changed without a report");
`endif

endmodule

// ----- hdl/mouse_click_classifier.sv -----
// ----------------------------------------------------------------------------
// mouse_click_classifier
// Mouse report classifier: input register, combinational classify with
// registered state update, result register.
// ----------------------------------------------------------------------------
// A report passes through the input register, then the result register.
// Throughput: one report per cycle while rsp_ready is high, set by the core.
// The input register can still fill once while the result register waits.
// Reset: tracker state cleared to zero, windows to 250 and 500 ms, wheel mask
// to 24, both pipeline registers empty.
module mouse_click_classifier (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  mcc_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output mcc_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mcc_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [mcc_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   mcc_pkg::cfg_type cfg;
   mcc_pkg::req_type req_ff;
   mcc_pkg::rsp_type rsp_ff, result;
   logic             req_valid_ff, rsp_valid_ff;
   logic             advance;

   // advance the registered report into the result register when it has room
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   mcc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mcc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (advance),
      .item       (req_ff),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            req_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

endmodule
